/* sv/cdi_pkg.sv */
`timescale 1ns / 1ps

package cdi_pkg;

    // Denomination table, smallest first: 1, 5, 10, 50
    localparam int NUM_DENOMS  = 4;
    localparam int DENOM_IDX_W = 2;
    localparam int DENOM_W     = 6;
    localparam int AMOUNT_W    = 12;
    localparam int GIVE_W      = 8;
    localparam int GIVE_MAX    = 255;

    // Division by a denomination: q = (rem * RECIP) >> RECIP_SHIFT, exact for 12-bit rem
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = AMOUNT_W + RECIP_W;

    typedef logic [DENOM_W-1:0] denom_t;
    typedef logic [RECIP_W-1:0] recip_t;

    localparam denom_t DENOM_VALUE [NUM_DENOMS] = '{6'd1, 6'd5, 6'd10, 6'd50};
    localparam recip_t DENOM_RECIP [NUM_DENOMS] =
        '{19'd262144, 19'd52429, 19'd26215, 19'd5243};
    localparam int unsigned DENOM_RESET [NUM_DENOMS] = '{30, 10, 8, 2};

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOTE_REJECT = 2'd1,
        STATUS_PAY_SHORT   = 2'd2,
        STATUS_NO_CHANGE   = 2'd3
    } status_t;

    // Datapath operations selected by the control word
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_CHECK,
        OP_QUOT,
        OP_TAKE,
        OP_SETTLE,
        OP_LOAD,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NOT_ACCEPT,
        COND_LOAD_MODE,
        COND_SHORT,
        COND_MORE_DENOMS,
        COND_OUT_BUSY
    } cond_t;

    typedef logic [2:0] step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  last;
    } ucode_t;

    // Status flags from datapath to sequencer
    typedef struct packed {
        logic accept;
        logic load_mode;
        logic pay_short;
        logic more_denoms;
        logic out_busy;
    } dp_flags_t;

endpackage

/* sv/cdi_seq.sv */
`timescale 1ns / 1ps

module cdi_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  cdi_pkg::dp_flags_t flags,
    output cdi_pkg::op_t      op
);
    import cdi_pkg::*;

    localparam step_t STEP_WAIT   = 3'd0;
    localparam step_t STEP_CHECK  = 3'd1;
    localparam step_t STEP_QUOT   = 3'd2;
    localparam step_t STEP_TAKE   = 3'd3;
    localparam step_t STEP_SETTLE = 3'd4;
    localparam step_t STEP_LOAD   = 3'd5;
    localparam step_t STEP_EMIT   = 3'd6;

    // Control store
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            STEP_WAIT:   w = '{OP_WAIT,   COND_NOT_ACCEPT,  STEP_WAIT,   1'b0};
            STEP_CHECK:  w = '{OP_CHECK,  COND_LOAD_MODE,   STEP_LOAD,   1'b0};
            STEP_QUOT:   w = '{OP_QUOT,   COND_SHORT,       STEP_EMIT,   1'b0};
            STEP_TAKE:   w = '{OP_TAKE,   COND_MORE_DENOMS, STEP_QUOT,   1'b0};
            STEP_SETTLE: w = '{OP_SETTLE, COND_ALWAYS,      STEP_EMIT,   1'b0};
            STEP_LOAD:   w = '{OP_LOAD,   COND_NONE,        STEP_WAIT,   1'b0};
            STEP_EMIT:   w = '{OP_EMIT,   COND_OUT_BUSY,    STEP_EMIT,   1'b1};
            default:     w = '{OP_WAIT,   COND_ALWAYS,      STEP_WAIT,   1'b0};
        endcase
        return w;
    endfunction

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   jump;

    assign word = ucode_rom(step_reg);
    assign op   = word.op;

    // Evaluate the jump condition
    always_comb begin
        case (word.cond)
            COND_NONE:        jump = 1'b0;
            COND_ALWAYS:      jump = 1'b1;
            COND_NOT_ACCEPT:  jump = !flags.accept;
            COND_LOAD_MODE:   jump = flags.load_mode;
            COND_SHORT:       jump = flags.pay_short;
            COND_MORE_DENOMS: jump = flags.more_denoms;
            COND_OUT_BUSY:    jump = flags.out_busy;
            default:          jump = 1'b0;
        endcase
    end

    // Advance the step counter
    always_comb begin
        if (jump) begin
            step_next = word.target;
        end else if (word.last) begin
            step_next = STEP_WAIT;
        end else begin
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* sv/cdi_datapath.sv */
`timescale 1ns / 1ps

module cdi_datapath #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cdi_pkg::op_t       op,
    output cdi_pkg::dp_flags_t flags,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [7:0]         s_note_value,
    input  logic [11:0]        s_price,
    input  logic [11:0]        s_paid,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [11:0]        m_change_total,
    output logic [7:0]         m_give_fifties,
    output logic [7:0]         m_give_tens,
    output logic [7:0]         m_give_fives,
    output logic [7:0]         m_give_ones
);
    import cdi_pkg::*;

    localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH) - 1;
    localparam int CMP_W = (COUNT_WIDTH > AMOUNT_W) ? COUNT_WIDTH : AMOUNT_W;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [GIVE_W-1:0]      give_t;

    // Captured item
    logic                  mode_reg;
    logic [7:0]            note_reg;
    logic [AMOUNT_W-1:0]   price_reg;
    logic [AMOUNT_W-1:0]   paid_reg;

    // Working state
    count_t                stock_reg  [NUM_DENOMS];
    count_t                stock_next [NUM_DENOMS];
    give_t                 take_reg   [NUM_DENOMS];
    give_t                 take_next  [NUM_DENOMS];
    logic [DENOM_IDX_W-1:0] d_reg;
    logic [DENOM_IDX_W-1:0] d_next;
    logic [AMOUNT_W-1:0]   rem_reg;
    logic [AMOUNT_W-1:0]   rem_next;
    logic [AMOUNT_W-1:0]   change_reg;
    logic [AMOUNT_W-1:0]   change_next;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic                  short_reg;
    logic                  short_next;
    status_t               status_reg;
    status_t               status_next;

    // Output register
    logic                  m_valid_reg;
    logic                  m_valid_next;
    status_t               out_status_reg;
    logic [AMOUNT_W-1:0]   out_change_reg;
    give_t                 out_take_reg [NUM_DENOMS];

    logic                  accept;
    logic                  out_free;
    logic [AMOUNT_W-1:0]   quot;
    logic [CMP_W-1:0]      quot_ext;
    logic [CMP_W-1:0]      stock_ext;
    logic [CMP_W-1:0]      lim;
    give_t                 n_take;
    logic [AMOUNT_W+1:0]   n_times_d;
    logic                  note_hit;
    logic [DENOM_IDX_W-1:0] note_idx;

    assign s_ready  = (op == OP_WAIT);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign flags.accept      = accept;
    assign flags.load_mode   = !mode_reg;
    assign flags.pay_short   = short_reg;
    assign flags.more_denoms = (d_reg != '0);
    assign flags.out_busy    = !out_free;

    // Greedy step: notes of this denomination, capped by stock and field range
    assign quot      = prod_reg[RECIP_SHIFT +: AMOUNT_W];
    assign quot_ext  = CMP_W'(quot);
    assign stock_ext = CMP_W'(stock_reg[d_reg]);
    assign lim       = (quot_ext < stock_ext) ? quot_ext : stock_ext;
    assign n_take    = (lim > CMP_W'(GIVE_MAX)) ? give_t'(GIVE_MAX) : lim[GIVE_W-1:0];
    assign n_times_d = {6'd0, n_take} * {8'd0, DENOM_VALUE[d_reg]};

    // Match the offered note against the denominations
    always_comb begin
        note_hit = 1'b0;
        note_idx = '0;
        for (int i = 0; i < NUM_DENOMS; i++) begin
            if (note_reg == {2'b00, DENOM_VALUE[i]}) begin
                note_hit = 1'b1;
                note_idx = DENOM_IDX_W'(i);
            end
        end
    end

    // Execute the current operation
    always_comb begin
        d_next       = d_reg;
        rem_next     = rem_reg;
        change_next  = change_reg;
        prod_next    = prod_reg;
        short_next   = short_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        for (int i = 0; i < NUM_DENOMS; i++) begin
            stock_next[i] = stock_reg[i];
            take_next[i]  = take_reg[i];
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (op)
            OP_CHECK: begin
                short_next  = (price_reg > paid_reg);
                rem_next    = paid_reg - price_reg;
                change_next = (price_reg > paid_reg) ? '0 : paid_reg - price_reg;
                status_next = (price_reg > paid_reg) ? STATUS_PAY_SHORT : STATUS_OK;
                d_next      = DENOM_IDX_W'(NUM_DENOMS - 1);
                for (int i = 0; i < NUM_DENOMS; i++) begin
                    take_next[i] = '0;
                end
            end
            OP_QUOT: begin
                prod_next = PROD_W'(rem_reg) * PROD_W'(DENOM_RECIP[d_reg]);
            end
            OP_TAKE: begin
                take_next[d_reg] = n_take;
                rem_next         = rem_reg - n_times_d[AMOUNT_W-1:0];
                d_next           = d_reg - 1'b1;
            end
            OP_SETTLE: begin
                if (rem_reg != '0) begin
                    status_next = STATUS_NO_CHANGE;
                    change_next = '0;
                    for (int i = 0; i < NUM_DENOMS; i++) begin
                        take_next[i] = '0;
                    end
                end else begin
                    for (int i = 0; i < NUM_DENOMS; i++) begin
                        stock_next[i] = stock_reg[i] - COUNT_WIDTH'(take_reg[i]);
                    end
                end
            end
            OP_LOAD: begin
                change_next = '0;
                for (int i = 0; i < NUM_DENOMS; i++) begin
                    take_next[i] = '0;
                end
                if (note_hit) begin
                    status_next = STATUS_OK;
                    if (stock_reg[note_idx] != count_t'(COUNT_MAX)) begin
                        stock_next[note_idx] = stock_reg[note_idx] + 1'b1;
                    end
                end else begin
                    status_next = STATUS_NOTE_REJECT;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and stock registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            d_reg       <= '0;
            short_reg   <= 1'b0;
            for (int i = 0; i < NUM_DENOMS; i++) begin
                stock_reg[i] <= count_t'((DENOM_RESET[i] < COUNT_MAX) ?
                                         DENOM_RESET[i] : COUNT_MAX);
            end
        end else begin
            m_valid_reg <= m_valid_next;
            d_reg       <= d_next;
            short_reg   <= short_next;
            for (int i = 0; i < NUM_DENOMS; i++) begin
                stock_reg[i] <= stock_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            note_reg  <= s_note_value;
            price_reg <= s_price;
            paid_reg  <= s_paid;
        end
        rem_reg    <= rem_next;
        change_reg <= change_next;
        prod_reg   <= prod_next;
        status_reg <= status_next;
        for (int i = 0; i < NUM_DENOMS; i++) begin
            take_reg[i] <= take_next[i];
        end
        if (op == OP_EMIT && out_free) begin
            out_status_reg <= status_reg;
            out_change_reg <= change_reg;
            for (int i = 0; i < NUM_DENOMS; i++) begin
                out_take_reg[i] <= take_reg[i];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_status_reg;
    assign m_change_total = out_change_reg;
    assign m_give_fifties = out_take_reg[3];
    assign m_give_tens    = out_take_reg[2];
    assign m_give_fives   = out_take_reg[1];
    assign m_give_ones    = out_take_reg[0];

endmodule

/* sv/change_dispenser_with_inventory.sv */
`timescale 1ns / 1ps
// Load item or short-paid purchase: WAIT, CHECK, then LOAD or QUOT, then EMIT.
// Other purchase item: WAIT, CHECK, a QUOT and TAKE pair per denomination, SETTLE, EMIT.
// The purchase path is set by the greedy loop: two control steps per denomination, four
// denominations, on one shared reciprocal multiplier. A finished result waits in the output
// register, so the next item is taken, back in WAIT, while it is still pending.
// Synchronous active-low reset loads stock 30, 10, 8, 2 (1, 5, 10, 50), capped to the count range.

module change_dispenser_with_inventory #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_note_value,
    input  logic [11:0] s_price,
    input  logic [11:0] s_paid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [11:0] m_change_total,
    output logic [7:0]  m_give_fifties,
    output logic [7:0]  m_give_tens,
    output logic [7:0]  m_give_fives,
    output logic [7:0]  m_give_ones
);
    import cdi_pkg::*;

    op_t       op;
    dp_flags_t flags;

    // Microcode sequencer
    cdi_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .op      (op)
    );

    // Stock, greedy arithmetic and output register
    cdi_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .flags          (flags),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_note_value   (s_note_value),
        .s_price        (s_price),
        .s_paid         (s_paid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_change_total (m_change_total),
        .m_give_fifties (m_give_fifties),
        .m_give_tens    (m_give_tens),
        .m_give_fives   (m_give_fives),
        .m_give_ones    (m_give_ones)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import cdi_pkg::*;

    localparam int          CW            = 8;
    localparam int unsigned COUNT_TOP     = (1 << CW) - 1;
    localparam int          RESET_CYCLES  = 12;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 24;
    localparam int unsigned AMOUNT_TOP    = (1 << AMOUNT_W) - 1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_BUY  = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [7:0]          note;
        logic [AMOUNT_W-1:0] price;
        logic [AMOUNT_W-1:0] paid;
    } order_t;

    // give[0] counts ones, give[3] counts fifties
    typedef struct packed {
        status_t                              status;
        logic [AMOUNT_W-1:0]                  change_total;
        logic [NUM_DENOMS-1:0][GIVE_W-1:0]    give;
    } payout_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_mode         = 1'b0;
    logic [7:0]          s_note_value   = '0;
    logic [AMOUNT_W-1:0] s_price        = '0;
    logic [AMOUNT_W-1:0] s_paid         = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [1:0]          m_status;
    logic [11:0]         m_change_total;
    logic [7:0]          m_give_fifties;
    logic [7:0]          m_give_tens;
    logic [7:0]          m_give_fives;
    logic [7:0]          m_give_ones;

    order_t      orders [$];
    payout_t     payouts_due [$];
    order_t      on_wire;
    payout_t     due_now;
    int unsigned stock_on_hand [NUM_DENOMS];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          mismatches    = 0;
    int          results_seen  = 0;
    int          hold_left     = 0;

    change_dispenser_with_inventory #(
        .COUNT_WIDTH(CW)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_note_value   (s_note_value),
        .s_price        (s_price),
        .s_paid         (s_paid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_change_total (m_change_total),
        .m_give_fifties (m_give_fifties),
        .m_give_tens    (m_give_tens),
        .m_give_fives   (m_give_fives),
        .m_give_ones    (m_give_ones)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Apply one item to the stock and work out the payout it should produce
    function automatic payout_t dispense_predict(input order_t o);
        payout_t                           r;
        logic [NUM_DENOMS-1:0][GIVE_W-1:0] pick;
        int unsigned                       owed;
        int unsigned                       left;
        int unsigned                       n;
        int                                d;
        r = '0;
        pick = '0;
        r.status = STATUS_OK;
        if (o.mode == MODE_LOAD) begin
            r.status = STATUS_NOTE_REJECT;
            for (d = 0; d < NUM_DENOMS; d++) begin
                if (o.note == DENOM_VALUE[d]) begin
                    // saturate at the top of the count range
                    if (stock_on_hand[d] < COUNT_TOP) stock_on_hand[d]++;
                    r.status = STATUS_OK;
                end
            end
            return r;
        end
        if (o.price > o.paid) begin
            r.status = STATUS_PAY_SHORT;
            return r;
        end
        // Greedy pick from the largest note down, limited by stock
        owed = o.paid - o.price;
        left = owed;
        for (d = NUM_DENOMS - 1; d >= 0; d--) begin
            n = left / DENOM_VALUE[d];
            if (n > stock_on_hand[d]) n = stock_on_hand[d];
            if (n > GIVE_MAX) n = GIVE_MAX;
            pick[d] = GIVE_W'(n);
            left -= n * DENOM_VALUE[d];
        end
        if (left != 0) begin
            r.status = STATUS_NO_CHANGE;
            return r;
        end
        for (d = 0; d < NUM_DENOMS; d++) stock_on_hand[d] -= pick[d];
        r.change_total = AMOUNT_W'(owed);
        r.give = pick;
        return r;
    endfunction

    function automatic order_t load_order(input logic [7:0] note);
        order_t o;
        o.mode  = MODE_LOAD;
        o.note  = note;
        o.price = AMOUNT_W'($urandom);
        o.paid  = AMOUNT_W'($urandom);
        return o;
    endfunction

    function automatic order_t buy_order(input int unsigned price, input int unsigned paid);
        order_t o;
        o.mode  = MODE_BUY;
        o.note  = 8'($urandom);
        o.price = AMOUNT_W'(price);
        o.paid  = AMOUNT_W'(paid);
        return o;
    endfunction

    // Mostly valid notes and well-formed purchases, with some noise
    function automatic order_t random_order(input int unsigned load_pct);
        int unsigned roll;
        int unsigned owed;
        int unsigned price;
        roll = $urandom_range(0, 99);
        if (roll < load_pct) begin
            if ($urandom_range(0, 99) < 85)
                return load_order(8'(DENOM_VALUE[$urandom_range(0, NUM_DENOMS - 1)]));
            return load_order(8'($urandom));
        end
        if (roll >= 92) return buy_order($urandom_range(0, AMOUNT_TOP),
                                         $urandom_range(0, AMOUNT_TOP));
        case ($urandom_range(0, 3))
            0: owed = $urandom_range(0, 99);
            1: owed = $urandom_range(0, 400);
            2: owed = 5 * $urandom_range(0, 80);
            default: owed = $urandom_range(0, AMOUNT_TOP);
        endcase
        price = $urandom_range(0, AMOUNT_TOP - owed);
        return buy_order(price, price + owed);
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Hold until every queued item has gone out and every payout has come back
    task automatic wait_all_paid();
        while (orders.size() != 0 || s_valid || payouts_due.size() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Drive items from the queue; predict each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) payouts_due.push_back(dispense_predict(on_wire));
            if (!s_valid || s_ready) begin
                if (orders.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    on_wire = orders.pop_front();
                    s_valid      <= 1'b1;
                    s_mode       <= on_wire.mode;
                    s_note_value <= on_wire.note;
                    s_price      <= on_wire.price;
                    s_paid       <= on_wire.paid;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each payout against the oldest prediction; throttle the result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (payouts_due.size() == 0) begin
                    $error("payout with no item pending: status %0d", m_status);
                    mismatches++;
                end else begin
                    due_now = payouts_due.pop_front();
                    check_field("status", 16'(due_now.status), 16'(m_status));
                    check_field("change_total", 16'(due_now.change_total), 16'(m_change_total));
                    check_field("give_fifties", 16'(due_now.give[3]), 16'(m_give_fifties));
                    check_field("give_tens", 16'(due_now.give[2]), 16'(m_give_tens));
                    check_field("give_fives", 16'(due_now.give[1]), 16'(m_give_fives));
                    check_field("give_ones", 16'(due_now.give[0]), 16'(m_give_ones));
                end
                results_seen++;
                // long back-pressure so the block fills and stalls its input
                if (results_seen == 150 || results_seen == 1300) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int d;
        for (d = 0; d < NUM_DENOMS; d++)
            stock_on_hand[d] = (DENOM_RESET[d] > COUNT_TOP) ? COUNT_TOP : DENOM_RESET[d];
        send_idle_pct = 11;
        recv_idle_pct = 52;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Notes: each denomination, then rejected values
        orders.push_back(load_order(8'd1));
        orders.push_back(load_order(8'd5));
        orders.push_back(load_order(8'd10));
        orders.push_back(load_order(8'd50));
        orders.push_back(load_order(8'd0));
        orders.push_back(load_order(8'd255));
        orders.push_back(load_order(8'd2));
        orders.push_back(load_order(8'd100));
        // Purchases: exact, short, unavailable and normal change
        orders.push_back(buy_order(0, 0));
        orders.push_back(buy_order(AMOUNT_TOP, 0));
        orders.push_back(buy_order(AMOUNT_TOP, AMOUNT_TOP));
        orders.push_back(buy_order(100, 99));
        orders.push_back(buy_order(0, AMOUNT_TOP));
        orders.push_back(buy_order(10, 97));
        orders.push_back(buy_order(0, 3));
        orders.push_back(buy_order(0, 200));
        orders.push_back(buy_order(7, 45));
        orders.push_back(buy_order(300, 329));
        orders.push_back(buy_order(1, 2));
        orders.push_back(buy_order(2048, 2047));
        repeat (560) orders.push_back(random_order(45));
        wait_all_paid();

        send_idle_pct = 52;
        recv_idle_pct = 11;
        // Fill the fifties past saturation, then spend them
        repeat (260) orders.push_back(load_order(8'd50));
        repeat (340) orders.push_back(random_order(35));
        wait_all_paid();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (570) orders.push_back(random_order(45));
        wait_all_paid();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (payouts_due.size() != 0) begin
            $error("%0d payouts never arrived", payouts_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("change_dispenser_with_inventory test passed");
        end else begin
            $display("change_dispenser_with_inventory test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("change_dispenser_with_inventory test failed");
        $finish;
    end

endmodule

/* change_dispenser_with_inventory.f */
sv/cdi_pkg.sv
sv/cdi_seq.sv
sv/cdi_datapath.sv
sv/change_dispenser_with_inventory.sv
bench/tb.sv
